### rtl/dtq_pkg.sv
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types and codes for the delta-list timer queue: operation and status
// codes, controller states, and the command and status bundles that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package dtq_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef struct packed {
        logic [15:0] thread;
        logic [15:0] delta;
        logic [7:0]  sem;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_PRIME,
        S_WALK,
        S_UP_RD,
        S_UP_WR,
        S_PUT_SUCC,
        S_PUT_NEW,
        S_DN_RD,
        S_DN_WR,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        RD_ZERO,
        RD_NEXT,
        RD_UP,
        RD_DN
    } rd_sel_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_UP,
        WR_DN,
        WR_SUCC,
        WR_NEW
    } wr_sel_t;

    typedef struct packed {
        logic    load;
        logic    walk_adv;
        logic    sub_wait;
        logic    hold;
        logic    sh_init_up;
        logic    sh_init_dn;
        logic    sh_dec;
        logic    sh_inc;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    set_status;
        status_t status_val;
        rd_sel_t rd_sel;
        wr_sel_t wr_sel;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic full;
        logic empty;
        logic le;
        logic match;
        logic last;
        logic up_done;
        logic dn_done;
    } dp_stat_t;

endpackage

### rtl/dtq_datapath.sv
// ----------------------------------------------------------------------------
// dtq_datapath
// Entry store, walk and shift counters, remaining-wait register and result
// registers of the delta-list timer queue. Acts only on controller commands.
// ----------------------------------------------------------------------------
module dtq_datapath
    import dtq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    input  logic [1:0]  op,
    input  logic [15:0] thread_id,
    input  logic [15:0] wait_time,
    input  logic [7:0]  sem_tag,
    output dp_stat_t    stat,
    output logic [1:0]  status,
    output logic [4:0]  entry_count,
    output logic [15:0] head_delta
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem [DEPTH];
    entry_t             rdata_reg;
    entry_t             held_reg;
    op_t                op_reg;
    logic [15:0]        tid_reg;
    logic [15:0]        wait_reg;
    logic [7:0]         sem_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   pos_reg;
    logic [CNT_W-1:0]   sh_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [15:0]        head_reg;
    status_t            status_reg;

    logic [CNT_W-1:0]   rd_full_addr;
    logic [CNT_W-1:0]   wr_full_addr;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    entry_t             wr_data;
    logic               wr_en;
    logic [CNT_W-1:0]   idx_plus;
    logic [CNT_W-1:0]   pos_plus;
    logic [31:0]        count_wide;

    assign idx_plus = idx_reg + CNT_W'(1);
    assign pos_plus = pos_reg + CNT_W'(1);

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_ZERO: rd_full_addr = '0;
            RD_NEXT: rd_full_addr = idx_plus;
            RD_UP:   rd_full_addr = sh_reg - CNT_W'(1);
            RD_DN:   rd_full_addr = sh_reg;
            default: rd_full_addr = '0;
        endcase
    end

    assign rd_addr = rd_full_addr[IDX_W-1:0];

    always_comb
    begin
        wr_en        = 1'b1;
        wr_full_addr = '0;
        wr_data      = rdata_reg;
        unique case (cmd.wr_sel)
            WR_NONE:
            begin
                wr_en = 1'b0;
            end
            WR_UP:
            begin
                wr_full_addr = sh_reg;
            end
            WR_DN:
            begin
                wr_full_addr = sh_reg - CNT_W'(1);
                if (sh_reg == pos_plus)
                begin
                    wr_data.delta = rdata_reg.delta + held_reg.delta;
                end
            end
            WR_SUCC:
            begin
                wr_full_addr  = pos_plus;
                wr_data       = held_reg;
                wr_data.delta = held_reg.delta - wait_reg;
            end
            WR_NEW:
            begin
                wr_full_addr = pos_reg;
                wr_data      = '{thread: tid_reg, delta: wait_reg, sem: sem_reg};
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign wr_addr = wr_full_addr[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op_t'(op);
            tid_reg  <= thread_id;
            wait_reg <= wait_time;
            sem_reg  <= sem_tag;
            idx_reg  <= '0;
            pos_reg  <= '0;
        end
        else
        begin
            if (cmd.sub_wait)
            begin
                wait_reg <= wait_reg - rdata_reg.delta;
            end
            if (cmd.walk_adv)
            begin
                idx_reg <= idx_plus;
                pos_reg <= idx_plus;
            end
            if (cmd.hold)
            begin
                held_reg <= rdata_reg;
                pos_reg  <= idx_reg;
            end
        end
        if (cmd.sh_init_up)
        begin
            sh_reg <= count_reg;
        end
        else if (cmd.sh_init_dn)
        begin
            sh_reg <= idx_plus;
        end
        else if (cmd.sh_dec)
        begin
            sh_reg <= sh_reg - CNT_W'(1);
        end
        else if (cmd.sh_inc)
        begin
            sh_reg <= sh_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            head_reg   <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.cnt_dec)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (wr_en && (wr_full_addr == '0))
            begin
                head_reg <= wr_data.delta;
            end
            if (cmd.set_status)
            begin
                status_reg <= cmd.status_val;
            end
        end
    end

    always_comb
    begin
        stat.op      = op_reg;
        stat.full    = (count_reg == CNT_W'(DEPTH));
        stat.empty   = (count_reg == '0);
        stat.le      = (rdata_reg.delta <= wait_reg);
        stat.match   = (rdata_reg.thread == tid_reg);
        stat.last    = (idx_plus == count_reg);
        stat.up_done = (sh_reg == pos_plus);
        stat.dn_done = (sh_reg == count_reg);
    end

    assign count_wide  = 32'(count_reg);
    assign status      = status_reg;
    assign entry_count = count_wide[4:0];
    assign head_delta  = (count_reg == '0) ? 16'd0 : head_reg;

endmodule

### rtl/dtq_ctrl.sv
// ----------------------------------------------------------------------------
// dtq_ctrl
// Controller of the delta-list timer queue. Sequences the walk over the
// entries, the shift that opens or closes a gap, and the result strobe.
// ----------------------------------------------------------------------------
module dtq_ctrl
    import dtq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     busy,
    output logic     done
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.op)
                    OP_INSERT:
                    begin
                        if (stat.full)
                        begin
                            state_next = S_DONE;
                        end
                        else if (stat.empty)
                        begin
                            state_next = S_PUT_NEW;
                        end
                        else
                        begin
                            state_next = S_PRIME;
                        end
                    end
                    OP_REMOVE, OP_LOOKUP:
                    begin
                        state_next = stat.empty ? S_DONE : S_PRIME;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_PRIME:
            begin
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (stat.op == OP_INSERT)
                begin
                    if (!stat.le)
                    begin
                        state_next = S_UP_RD;
                    end
                    else if (stat.last)
                    begin
                        state_next = S_PUT_NEW;
                    end
                end
                else if (stat.match)
                begin
                    state_next = (stat.op == OP_REMOVE) ? S_DN_RD : S_DONE;
                end
                else if (stat.last)
                begin
                    state_next = S_DONE;
                end
            end
            S_UP_RD:
            begin
                state_next = stat.up_done ? S_PUT_SUCC : S_UP_WR;
            end
            S_UP_WR:
            begin
                state_next = S_UP_RD;
            end
            S_PUT_SUCC:
            begin
                state_next = S_PUT_NEW;
            end
            S_PUT_NEW:
            begin
                state_next = S_DONE;
            end
            S_DN_RD:
            begin
                state_next = stat.dn_done ? S_DONE : S_DN_WR;
            end
            S_DN_WR:
            begin
                state_next = S_DN_RD;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.status_val = ST_OK;
        cmd.rd_sel     = RD_ZERO;
        cmd.wr_sel     = WR_NONE;
        busy           = (state_reg != S_IDLE);
        done           = (state_reg == S_DONE);
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
            end
            S_DECODE:
            begin
                cmd.set_status = 1'b1;
                unique case (stat.op)
                    OP_INSERT:
                    begin
                        cmd.status_val = stat.full ? ST_FULL : ST_OK;
                    end
                    OP_REMOVE, OP_LOOKUP:
                    begin
                        cmd.status_val = stat.empty ? ST_NOT_FOUND : ST_OK;
                    end
                    default:
                    begin
                        cmd.status_val = ST_OK;
                    end
                endcase
            end
            S_PRIME:
            begin
                cmd.rd_sel = RD_ZERO;
            end
            S_WALK:
            begin
                cmd.rd_sel = RD_NEXT;
                if (stat.op == OP_INSERT)
                begin
                    if (stat.le)
                    begin
                        cmd.walk_adv = 1'b1;
                        cmd.sub_wait = 1'b1;
                    end
                    else
                    begin
                        cmd.hold       = 1'b1;
                        cmd.sh_init_up = 1'b1;
                    end
                end
                else if (stat.match)
                begin
                    cmd.hold       = 1'b1;
                    cmd.sh_init_dn = 1'b1;
                end
                else if (stat.last)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status_val = ST_NOT_FOUND;
                end
                else
                begin
                    cmd.walk_adv = 1'b1;
                end
            end
            S_UP_RD:
            begin
                cmd.rd_sel = RD_UP;
            end
            S_UP_WR:
            begin
                cmd.wr_sel = WR_UP;
                cmd.sh_dec = 1'b1;
            end
            S_PUT_SUCC:
            begin
                cmd.wr_sel = WR_SUCC;
            end
            S_PUT_NEW:
            begin
                cmd.wr_sel  = WR_NEW;
                cmd.cnt_inc = 1'b1;
            end
            S_DN_RD:
            begin
                cmd.rd_sel  = RD_DN;
                cmd.cnt_dec = stat.dn_done;
            end
            S_DN_WR:
            begin
                cmd.wr_sel = WR_DN;
                cmd.sh_inc = 1'b1;
            end
            S_DONE:
            begin
                cmd.load = 1'b0;
            end
            default:
            begin
                cmd.load = 1'b0;
            end
        endcase
    end

endmodule

### rtl/delta_timer_queue_top.sv
// ----------------------------------------------------------------------------
// delta_timer_queue_top
// An operation runs from start to the done strobe; the shortest ones (insert
// when full, remove or lookup when empty, unused code) go from decode straight
// to done. The single-port walk reads one entry a cycle and the shift moves
// one entry with each read state and write state pair. The next operation is
// accepted in the cycle after done. Reset clears the entry count, so the queue
// comes up empty; the entry store itself is not cleared.
// ----------------------------------------------------------------------------
module delta_timer_queue_top
    import dtq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [1:0]  op,
    input  logic [15:0] thread_id,
    input  logic [15:0] wait_time,
    input  logic [7:0]  sem_tag,
    output logic        busy,
    output logic        done,
    output logic [1:0]  status,
    output logic [4:0]  entry_count,
    output logic [15:0] head_delta
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    dtq_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    dtq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .op          (op),
        .thread_id   (thread_id),
        .wait_time   (wait_time),
        .sem_tag     (sem_tag),
        .stat        (stat),
        .status      (status),
        .entry_count (entry_count),
        .head_delta  (head_delta)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted transfer did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("queue still busy after result strobe");

    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_sel != WR_NONE) |-> busy)
        else $error("entry store written while idle");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_FULL)) |-> stat.full)
        else $error("full status reported on a queue that is not full");

endmodule

### verif/delta_timer_queue_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// delta_timer_queue_top_tb
// Drives insert, remove, lookup and unused commands into the delta-list timer
// queue. A scoreboard keeps its own copy of the queue, predicts the status,
// entry count and head delta of every command, and checks each done strobe.
// A directed opening covers the edge cases, then random traffic swings
// between filling and draining the queue.
// ----------------------------------------------------------------------------
module delta_timer_queue_top_tb;
    import dtq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int CLK_HALF    = 4;
    localparam int RANDOM_CMDS = 1625;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct {
        status_t     status;
        logic [4:0]  entry_count;
        logic [15:0] head_delta;
    } queue_result_t;

    class delta_queue_scoreboard;
        logic [15:0]   thread_q [DEPTH];
        logic [15:0]   delta_q [DEPTH];
        logic [7:0]    sem_q [DEPTH];
        int            count;
        int            errors;
        queue_result_t pending[$];

        function new();
            count  = 0;
            errors = 0;
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function int find_thread(logic [15:0] tid);
            for (int i = 0; i < count; i++)
            begin
                if (thread_q[i] == tid)
                    return i;
            end
            return -1;
        endfunction

        function status_t queue_insert(logic [15:0] tid, logic [15:0] ticks, logic [7:0] tag);
            int pos;
            int remaining;
            pos       = 0;
            remaining = ticks;
            if (count >= DEPTH)
                return ST_FULL;
            while (pos < count && delta_q[pos] <= remaining)
            begin
                remaining -= delta_q[pos];
                pos++;
            end
            for (int j = count; j > pos; j--)
            begin
                thread_q[j] = thread_q[j-1];
                delta_q[j]  = delta_q[j-1];
                sem_q[j]    = sem_q[j-1];
            end
            thread_q[pos] = tid;
            delta_q[pos]  = remaining[15:0];
            sem_q[pos]    = tag;
            count++;
            if (pos + 1 < count)
                delta_q[pos+1] = delta_q[pos+1] - remaining[15:0];
            return ST_OK;
        endfunction

        function status_t queue_remove(logic [15:0] tid);
            int pos;
            pos = find_thread(tid);
            if (pos < 0)
                return ST_NOT_FOUND;
            if (pos + 1 < count)
                delta_q[pos+1] = delta_q[pos+1] + delta_q[pos];
            for (int j = pos; j + 1 < count; j++)
            begin
                thread_q[j] = thread_q[j+1];
                delta_q[j]  = delta_q[j+1];
                sem_q[j]    = sem_q[j+1];
            end
            count--;
            return ST_OK;
        endfunction

        function void note_command(op_t cmd, logic [15:0] tid, logic [15:0] ticks,
                                   logic [7:0] tag);
            queue_result_t res;
            res.status = ST_OK;
            case (cmd)
                OP_INSERT: res.status = queue_insert(tid, ticks, tag);
                OP_REMOVE: res.status = queue_remove(tid);
                OP_LOOKUP: res.status = (find_thread(tid) >= 0) ? ST_OK : ST_NOT_FOUND;
                default:   res.status = ST_OK;
            endcase
            res.entry_count = count[4:0];
            res.head_delta  = (count > 0) ? delta_q[0] : 16'd0;
            pending.push_back(res);
        endfunction

        task check_result(logic [1:0] got_status, logic [4:0] got_count,
                          logic [15:0] got_head);
            queue_result_t want;
            if (pending.size() == 0)
            begin
                report("done strobe with no command outstanding");
                return;
            end
            want = pending.pop_front();
            if (got_status !== want.status)
                report($sformatf("status %0d, predicted %0d", got_status, want.status));
            if (got_count !== want.entry_count)
                report($sformatf("entry_count %0d, predicted %0d", got_count,
                                 want.entry_count));
            if (got_head !== want.head_delta)
                report($sformatf("head_delta %0d, predicted %0d", got_head,
                                 want.head_delta));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic [1:0]  op;
    logic [15:0] thread_id;
    logic [15:0] wait_time;
    logic [7:0]  sem_tag;
    logic        busy;
    logic        done;
    logic [1:0]  status;
    logic [4:0]  entry_count;
    logic [15:0] head_delta;

    delta_queue_scoreboard sb;
    int                    burst_left;
    int                    cycles;

    delta_timer_queue_top #(
        .DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .op(op),
        .thread_id(thread_id),
        .wait_time(wait_time),
        .sem_tag(sem_tag),
        .busy(busy),
        .done(done),
        .status(status),
        .entry_count(entry_count),
        .head_delta(head_delta)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            sb.check_result(status, entry_count, head_delta);
    end

    // Holds start high through a burst of transfers, then drops it for a gap.
    task send_command(op_t cmd, logic [15:0] tid, logic [15:0] ticks, logic [7:0] tag);
        start     <= 1'b1;
        op        <= cmd;
        thread_id <= tid;
        wait_time <= ticks;
        sem_tag   <= tag;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_command(cmd, tid, ticks, tag);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 12))
                @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    function logic [15:0] pick_ticks();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(0, 3));
            4, 5, 6: return 16'($urandom_range(0, 200));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function logic [15:0] pick_thread(bit prefer_queued);
        if (prefer_queued && sb.count > 0 && $urandom_range(0, 1) == 1)
            return sb.thread_q[$urandom_range(0, sb.count - 1)];
        if ($urandom_range(0, 99) < 85)
            return 16'($urandom_range(0, 23));
        return 16'($urandom_range(0, 65535));
    endfunction

    task run_random();
        bit filling;
        int roll;
        op_t cmd;
        filling = 1'b1;
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            if (sb.count == DEPTH && $urandom_range(0, 3) == 0)
                filling = 1'b0;
            else if (sb.count == 0 && $urandom_range(0, 2) == 0)
                filling = 1'b1;
            roll = $urandom_range(0, 99);
            if (filling)
                cmd = (roll < 65) ? OP_INSERT : (roll < 83) ? OP_REMOVE :
                      (roll < 97) ? OP_LOOKUP : OP_NONE;
            else
                cmd = (roll < 25) ? OP_INSERT : (roll < 75) ? OP_REMOVE :
                      (roll < 96) ? OP_LOOKUP : OP_NONE;
            send_command(cmd, pick_thread(cmd != OP_INSERT), pick_ticks(),
                         8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        sb         = new();
        cycles     = 0;
        burst_left = 0;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        op        <= OP_NONE;
        thread_id <= 16'd0;
        wait_time <= 16'd0;
        sem_tag   <= 8'd0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty queue, unused code, extreme fields, ties and duplicate ids.
        send_command(OP_LOOKUP, 16'd0, 16'd0, 8'd0);
        send_command(OP_REMOVE, 16'd5, 16'd0, 8'd0);
        send_command(OP_NONE, 16'hFFFF, 16'hFFFF, 8'hFF);
        send_command(OP_INSERT, 16'd0, 16'hFFFF, 8'hFF);
        send_command(OP_INSERT, 16'hFFFF, 16'd0, 8'd0);
        send_command(OP_INSERT, 16'd7, 16'hFFFF, 8'hAA);
        send_command(OP_INSERT, 16'd8, 16'd100, 8'h55);
        send_command(OP_INSERT, 16'd8, 16'd100, 8'h01);
        send_command(OP_LOOKUP, 16'd8, 16'd0, 8'd0);
        send_command(OP_LOOKUP, 16'd9, 16'd0, 8'd0);
        send_command(OP_REMOVE, 16'd8, 16'd0, 8'd0);
        send_command(OP_REMOVE, 16'hFFFF, 16'd0, 8'd0);
        send_command(OP_REMOVE, 16'd7, 16'd0, 8'd0);

        // Fill the queue, then insert once more into the full store.
        while (sb.count < DEPTH)
            send_command(OP_INSERT, pick_thread(1'b0), pick_ticks(),
                         8'($urandom_range(0, 255)));
        send_command(OP_INSERT, 16'd3, 16'd10, 8'd3);

        run_random();

        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (2 * DEPTH + 10)
            @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
